@@ rtl/dtr_pkg.sv @@
// ---------------------------------------------------------------------------
// dtr_pkg: shared types and constants of the thermostat relay unit
// Field widths, family codes, fault codes and fixed temperature points.
// ---------------------------------------------------------------------------
package dtr_pkg;

  localparam int LimitW = 10;
  localparam int TempW  = 20;
  localparam int CmpW   = 21;

  localparam logic [7:0] FamS  = 8'h10;
  localparam logic [7:0] FamB  = 8'h28;
  localparam logic [7:0] Fam22 = 8'h22;

  localparam logic [1:0] Res9  = 2'b00;
  localparam logic [1:0] Res10 = 2'b01;
  localparam logic [1:0] Res11 = 2'b10;

  localparam logic [7:0] ExtCountPerDeg = 8'd16;
  localparam logic [15:0] ExtOffset     = 16'd12;
  localparam logic signed [TempW-1:0] OffsetX80 = 20'sd2560;

  // -99.9 F stands in for a faulted reading, -70 F is the heat floor
  localparam logic signed [CmpW-1:0] FaultX80 = -21'sd7992;
  localparam logic signed [CmpW-1:0] FloorX80 = -21'sd5600;

  localparam logic signed [LimitW-1:0] HighLimitRst = 10'sd50;
  localparam logic signed [LimitW-1:0] LowLimitRst  = 10'sd45;

  localparam logic RegHighLimit = 1'b0;
  localparam logic RegLowLimit  = 1'b1;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_NO_DEV = 2'd1,
    FAULT_CRC    = 2'd2,
    FAULT_FAMILY = 2'd3
  } fault_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    fault_t                  fault;
  } dec_t;

endpackage

@@ rtl/dtr_decode.sv @@
// ---------------------------------------------------------------------------
// dtr_decode: sensor reading decode
// Checks the search and CRC flags and the family, then turns the scratchpad
// bytes into a signed temperature in 1/80 F.
// ---------------------------------------------------------------------------
module dtr_decode
  import dtr_pkg::*;
(
  input  logic       device_found,
  input  logic       rom_crc_ok,
  input  logic [7:0] family_code,
  input  logic [7:0] temp_low_byte,
  input  logic [7:0] temp_high_byte,
  input  logic [7:0] resolution_byte,
  input  logic [7:0] count_remain,
  input  logic [7:0] count_per_degree,
  output dec_t       dec
);

  logic [15:0] raw;
  logic [15:0] shifted;
  logic [15:0] word;
  logic signed [TempW-1:0] wide;
  fault_t fault;

  assign raw     = {temp_high_byte, temp_low_byte};
  assign shifted = {raw[12:0], 3'b000};

  always_comb begin
    if (!device_found) begin
      fault = FAULT_NO_DEV;
    end else if (!rom_crc_ok) begin
      fault = FAULT_CRC;
    end else if (family_code != FamS && family_code != FamB && family_code != Fam22) begin
      fault = FAULT_FAMILY;
    end else begin
      fault = FAULT_NONE;
    end
  end

  always_comb begin
    if (family_code == FamS) begin
      if (count_per_degree == ExtCountPerDeg) begin
        // extended resolution: drop the half-degree bit, add 0.75 - remain/16
        word = {shifted[15:4], 4'b0000} + ExtOffset - {8'd0, count_remain};
      end else begin
        word = shifted;
      end
    end else begin
      unique case (resolution_byte[6:5])
        Res9:    word = {raw[15:3], 3'b000};
        Res10:   word = {raw[15:2], 2'b00};
        Res11:   word = {raw[15:1], 1'b0};
        default: word = raw;
      endcase
    end
  end

  // raw * 9 + 2560 as shift-and-add
  assign wide = ({{1{word[15]}}, word, 3'b000}) + {{4{word[15]}}, word} + OffsetX80;

  always_comb begin
    dec.fault = fault;
    dec.temp  = (fault == FAULT_NONE) ? wide : '0;
  end

endmodule

@@ rtl/dtr_relay.sv @@
// ---------------------------------------------------------------------------
// dtr_relay: hysteresis relay control
// Compares each reading with the limits and keeps the relay level.
// ---------------------------------------------------------------------------
module dtr_relay
  import dtr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  dec_t                     dec,
  input  logic signed [LimitW-1:0] high_limit,
  input  logic signed [LimitW-1:0] low_limit,
  output logic                     level_next
);

  logic level;
  logic signed [CmpW-1:0] cmp;
  logic signed [CmpW-1:0] high_x80;
  logic signed [CmpW-1:0] low_x80;

  // limit * 80 = limit * 64 + limit * 16
  assign high_x80 = {{5{high_limit[LimitW-1]}}, high_limit, 6'd0}
                  + {{7{high_limit[LimitW-1]}}, high_limit, 4'd0};
  assign low_x80  = {{5{low_limit[LimitW-1]}}, low_limit, 6'd0}
                  + {{7{low_limit[LimitW-1]}}, low_limit, 4'd0};

  assign cmp = (dec.fault == FAULT_NONE) ? {dec.temp[TempW-1], dec.temp} : FaultX80;

  always_comb begin
    priority if (cmp > high_x80) begin
      level_next = 1'b0;
    end else if (cmp < low_x80 && cmp > FloorX80) begin
      level_next = 1'b1;
    end else begin
      level_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b0;
    end else if (update) begin
      level <= level_next;
    end
  end

endmodule

@@ rtl/ds18x20_thermostat_relay_unit.sv @@
// ---------------------------------------------------------------------------
// ds18x20_thermostat_relay_unit: temperature decode and thermostat relay
// Each input beat is one finished sensor reading; each output beat gives
// the temperature in 1/80 F, the relay level after that reading and a
// fault code.
//
// Channels use valid/stall: a beat moves on an edge with valid high and
// stall low. The input beat is captured in an input register; decode and
// the limit compare run from there into the result register, which drives
// out_valid. One beat per cycle is sustained while the output is not
// stalled; the path from input register to result register (decode, 20-bit
// add, limit compare) sets the rate.
// When the receiver stalls, the result holds, the input register still
// fills once, and in_stall rises only while both registers are full.
// Limits are written through cfg_write/cfg_index/cfg_data, by the user only
// while idle (the block does not enforce it). Reset empties both registers,
// turns the relay off and sets the limits to 50 F high and 45 F low.
// ---------------------------------------------------------------------------
module ds18x20_thermostat_relay_unit
  import dtr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [LimitW-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    device_found,
  input  logic                    rom_crc_ok,
  input  logic [7:0]              family_code,
  input  logic [7:0]              temp_low_byte,
  input  logic [7:0]              temp_high_byte,
  input  logic [7:0]              resolution_byte,
  input  logic [7:0]              count_remain,
  input  logic [7:0]              count_per_degree,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [TempW-1:0] temp_f_x80,
  output logic                    relay_on,
  output logic [1:0]              fault_code
);

  logic signed [LimitW-1:0] high_limit;
  logic signed [LimitW-1:0] low_limit;

  logic       s1_valid;
  logic       s1_found;
  logic       s1_crc_ok;
  logic [7:0] s1_family;
  logic [7:0] s1_lo;
  logic [7:0] s1_hi;
  logic [7:0] s1_res;
  logic [7:0] s1_remain;
  logic [7:0] s1_per_deg;

  logic load;
  logic move;
  dec_t dec;
  logic level_next;

  assign move     = s1_valid && (!out_valid || !out_stall);
  assign load     = in_valid && !in_stall;
  assign in_stall = s1_valid && !move;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit <= HighLimitRst;
      low_limit  <= LowLimitRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegHighLimit: high_limit <= cfg_data;
        RegLowLimit:  low_limit  <= cfg_data;
        default:      high_limit <= high_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_found   <= device_found;
      s1_crc_ok  <= rom_crc_ok;
      s1_family  <= family_code;
      s1_lo      <= temp_low_byte;
      s1_hi      <= temp_high_byte;
      s1_res     <= resolution_byte;
      s1_remain  <= count_remain;
      s1_per_deg <= count_per_degree;
    end
  end

  dtr_decode u_decode (
    .device_found     (s1_found),
    .rom_crc_ok       (s1_crc_ok),
    .family_code      (s1_family),
    .temp_low_byte    (s1_lo),
    .temp_high_byte   (s1_hi),
    .resolution_byte  (s1_res),
    .count_remain     (s1_remain),
    .count_per_degree (s1_per_deg),
    .dec              (dec)
  );

  dtr_relay u_relay (
    .clk        (clk),
    .rst        (rst),
    .update     (move),
    .dec        (dec),
    .high_limit (high_limit),
    .low_limit  (low_limit),
    .level_next (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      temp_f_x80 <= dec.temp;
      relay_on   <= level_next;
      fault_code <= dec.fault;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for ds18x20_thermostat_relay_unit
// Drives sensor readings over the valid/stall input channel and compares each
// output beat with an in-bench thermostat predictor. A directed table comes
// first, then randomized phases under several limit settings, with random
// idling on both sides, a long output hold-off and drained pauses.
// ---------------------------------------------------------------------------
module tb_top;
  import dtr_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 229;
  localparam int LongHold      = 60;

  typedef struct {
    logic       dev;
    logic       crc;
    logic [7:0] fam;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] res;
    logic [7:0] crem;
    logic [7:0] cpd;
  } reading_t;

  typedef struct {
    logic signed [TempW-1:0] temp;
    logic                    relay;
    fault_t                  fault;
  } readout_t;

  typedef struct {
    reading_t rd;
    bit       typed;
    readout_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = RegHighLimit;
  logic [LimitW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              device_found = 1'b0;
  logic              rom_crc_ok = 1'b0;
  logic [7:0]        family_code = '0;
  logic [7:0]        temp_low_byte = '0;
  logic [7:0]        temp_high_byte = '0;
  logic [7:0]        resolution_byte = '0;
  logic [7:0]        count_remain = '0;
  logic [7:0]        count_per_degree = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [TempW-1:0] temp_f_x80;
  logic              relay_on;
  logic [1:0]        fault_code;

  // bench copy of the thermostat state and limits
  logic     relay_model = 1'b0;
  int       high_lim = int'(HighLimitRst);
  int       low_lim = int'(LowLimitRst);

  readout_t pending_readouts[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;
  int       hold_req = 0;
  readout_t got_want;

  ds18x20_thermostat_relay_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .device_found     (device_found),
    .rom_crc_ok       (rom_crc_ok),
    .family_code      (family_code),
    .temp_low_byte    (temp_low_byte),
    .temp_high_byte   (temp_high_byte),
    .resolution_byte  (resolution_byte),
    .count_remain     (count_remain),
    .count_per_degree (count_per_degree),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .temp_f_x80       (temp_f_x80),
    .relay_on         (relay_on),
    .fault_code       (fault_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic readout_t predict_readout(reading_t rd);
    readout_t   o;
    logic [15:0] raw;
    int          t;
    int          cmp;
    o.temp  = '0;
    o.fault = FAULT_NONE;
    if (!rd.dev) o.fault = FAULT_NO_DEV;
    else if (!rd.crc) o.fault = FAULT_CRC;
    else if (rd.fam != FamS && rd.fam != FamB && rd.fam != Fam22) o.fault = FAULT_FAMILY;
    cmp = int'(FaultX80);
    if (o.fault == FAULT_NONE) begin
      raw = {rd.hi, rd.lo};
      if (rd.fam == FamS) begin
        raw = raw << 3;
        if (rd.cpd == ExtCountPerDeg) raw = (raw & 16'hFFF0) + ExtOffset - {8'h00, rd.crem};
      end else begin
        case (rd.res[6:5])
          Res9:    raw = raw & 16'hFFF8;
          Res10:   raw = raw & 16'hFFFC;
          Res11:   raw = raw & 16'hFFFE;
          default: ;
        endcase
      end
      t = int'($signed(raw)) * 9 + int'(OffsetX80);
      o.temp = t[TempW-1:0];
      cmp = t;
    end
    // high test first, so crossed limits switch off
    if (cmp > high_lim * 80) relay_model = 1'b0;
    else if (cmp < low_lim * 80 && cmp > int'(FloorX80)) relay_model = 1'b1;
    o.relay = relay_model;
    return o;
  endfunction

  function automatic reading_t random_reading();
    reading_t rd;
    int       kind;
    int       lim;
    int       v;
    kind    = $urandom_range(0, 99);
    rd.dev  = 1'b1;
    rd.crc  = 1'b1;
    case ($urandom_range(0, 2))
      0:       rd.fam = FamS;
      1:       rd.fam = FamB;
      default: rd.fam = Fam22;
    endcase
    rd.res  = 8'($urandom_range(0, 255));
    rd.crem = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 16))
                                          : 8'($urandom_range(0, 255));
    rd.cpd  = ($urandom_range(0, 1) == 0) ? ExtCountPerDeg : 8'($urandom_range(0, 255));
    if (kind < 4) begin
      rd.dev = 1'b0;
      rd.crc = 1'($urandom_range(0, 1));
    end else if (kind < 8) begin
      rd.crc = 1'b0;
    end
    if (kind < 12) rd.fam = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      {rd.hi, rd.lo} = 16'($urandom_range(0, 65535));
    end else begin
      // aim near a limit or the heat floor so the relay toggles
      case ($urandom_range(0, 2))
        0:       lim = high_lim * 80;
        1:       lim = low_lim * 80;
        default: lim = int'(FloorX80);
      endcase
      v = (lim - int'(OffsetX80)) / 9 + int'($urandom_range(0, 40)) - 20;
      if (rd.fam == FamS) v = (v >>> 3) + int'($urandom_range(0, 4)) - 2;
      {rd.hi, rd.lo} = v[15:0];
    end
    return rd;
  endfunction

  task automatic add_row(input logic dev, input logic crc, input logic [7:0] fam,
                         input logic [15:0] raw, input logic [7:0] res,
                         input logic [7:0] crem, input logic [7:0] cpd,
                         input int typed, input int temp, input logic relay,
                         input fault_t fault);
    dir_row_t r;
    r.rd.dev = dev;
    r.rd.crc = crc;
    r.rd.fam = fam;
    {r.rd.hi, r.rd.lo} = raw;
    r.rd.res  = res;
    r.rd.crem = crem;
    r.rd.cpd  = cpd;
    r.typed   = (typed != 0);
    r.want.temp  = temp[TempW-1:0];
    r.want.relay = relay;
    r.want.fault = fault;
    dir_rows.push_back(r);
  endtask

  task automatic send_reading(input reading_t rd, input bit typed, input readout_t want);
    int       gap;
    readout_t pred;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    device_found     <= rd.dev;
    rom_crc_ok       <= rd.crc;
    family_code      <= rd.fam;
    temp_low_byte    <= rd.lo;
    temp_high_byte   <= rd.hi;
    resolution_byte  <= rd.res;
    count_remain     <= rd.crem;
    count_per_degree <= rd.cpd;
    do @(posedge clk); while (in_stall);
    pred = predict_readout(rd);
    pending_readouts.push_back(typed ? want : pred);
  endtask

  // stop offering and wait until every result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input int h, input int l);
    cfg_write <= 1'b1;
    cfg_index <= RegHighLimit;
    cfg_data  <= h[LimitW-1:0];
    @(posedge clk);
    cfg_index <= RegLowLimit;
    cfg_data  <= l[LimitW-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    high_lim = int'($signed(h[LimitW-1:0]));
    low_lim  = int'($signed(l[LimitW-1:0]));
  endtask

  // receiver: random stall before each beat, or one long hold-off on request
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: temp %0d relay %0b fault %0d",
                                   temp_f_x80, relay_on, fault_code);
      end else begin
        got_want = pending_readouts.pop_front();
        if (temp_f_x80 !== got_want.temp || relay_on !== got_want.relay ||
            fault_code !== got_want.fault) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: temp %0d/%0d relay %0b/%0b fault %0d/%0d (exp/got)",
                     got_want.temp, temp_f_x80, got_want.relay, relay_on,
                     got_want.fault, fault_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    readout_t none;
    int       h;
    int       l;
    none.temp  = '0;
    none.relay = 1'b0;
    none.fault = FAULT_NONE;

    // faults and extremes after reset (limits 50/45, relay off)
    add_row(1'b0, 1'b1, FamB,  16'h0000, 8'h60, 8'h00, 8'h00, 1, 0, 1'b0, FAULT_NO_DEV);
    add_row(1'b1, 1'b0, FamB,  16'h0000, 8'h60, 8'h00, 8'h00, 1, 0, 1'b0, FAULT_CRC);
    add_row(1'b0, 1'b0, 8'h00, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1, 0, 1'b0, FAULT_NO_DEV);
    add_row(1'b1, 1'b1, 8'h00, 16'h1234, 8'h60, 8'h00, 8'h10, 1, 0, 1'b0, FAULT_FAMILY);
    add_row(1'b1, 1'b1, 8'hFF, 16'h1234, 8'h60, 8'h00, 8'h10, 1, 0, 1'b0, FAULT_FAMILY);
    add_row(1'b1, 1'b1, FamB,  16'h7FFF, 8'h60, 8'h00, 8'h00, 1, 297463, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'h8000, 8'h60, 8'h00, 8'h00, 1, -292352, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'h0000, 8'h7F, 8'h00, 8'h00, 1, 2560, 1'b1, FAULT_NONE);
    // resolution masking on both B-type families
    add_row(1'b1, 1'b1, FamB,  16'hFFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'hFFFF, 8'h20, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, Fam22, 16'hFFFF, 8'h40, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, Fam22, 16'hFFFF, 8'h9F, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'h0190, 8'h60, 8'h00, 8'h00, 1, 6160, 1'b0, FAULT_NONE);
    // S family: shift, count-remain extension and its wrap
    add_row(1'b1, 1'b1, FamS,  16'h0032, 8'h00, 8'h0C, 8'h10, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamS,  16'h00FF, 8'h00, 8'hFF, 8'h10, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamS,  16'hFFFF, 8'h00, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamS,  16'h8000, 8'hFF, 8'h55, 8'h0F, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamS,  16'h0000, 8'h00, 8'h00, 8'h10, 0, 0, 1'b0, FAULT_NONE);
    // exactly on the high limit holds; either side of the heat floor
    add_row(1'b1, 1'b1, FamB,  16'h00A0, 8'h60, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'hFC75, 8'h60, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'hFC76, 8'h60, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'h0190, 8'h60, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);
    add_row(1'b1, 1'b1, FamB,  16'hFC75, 8'h60, 8'h00, 8'h00, 0, 0, 1'b0, FAULT_NONE);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_reading(dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0:       begin h = 300;  l = -100; end
        1:       begin h = -100; l = -100; end
        2:       begin h = 511;  l = -512; end
        3:       begin h = -512; l = 511;  end
        4:       begin h = 32;   l = 32;   end
        5:       begin h = 40;   l = 70;   end
        6:       begin h = 80;   l = 60;   end
        default: begin
          h = $urandom_range(0, 400) - 100;
          l = $urandom_range(0, 400) - 100;
        end
      endcase
      set_limits(h, l);
      calm = (p == 2);
      if (p == 4) begin
        // back-to-back beats into a held output so the input stalls
        calm = 1'b1;
        hold_req = LongHold;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 4 && k == 30) calm = 1'b0;
        if (p == 6 && k == PhaseItems / 2) drain();
        send_reading(random_reading(), 1'b0, none);
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_readouts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
